>>> rtl/core/page_framebuffer_vertical_span_unit_assert.svh
// Assertion macros used by the checker of the vertical span unit.
// Depends on nothing; included by the checker file.
`ifndef PAGE_FRAMEBUFFER_VERTICAL_SPAN_UNIT_ASSERT_SVH
`define PAGE_FRAMEBUFFER_VERTICAL_SPAN_UNIT_ASSERT_SVH

// Same-cycle implication checked at every rising edge outside reset.
`define PFVS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vertical span unit check failed");

// Next-cycle implication checked at every rising edge outside reset.
`define PFVS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vertical span unit check failed");

`endif

>>> rtl/core/pfvs_pkg.sv
// Shared types and codes of the vertical span unit.
// Depends on nothing; used by the sequencer, the store, the top level and the checker.
`timescale 1ns / 1ps

package pfvs_pkg;

   // Operation codes carried in the opcode field.
   typedef enum logic [1:0] {
      OP_SET    = 2'd0,
      OP_INVERT = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_WIPE,
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   // Port enables from the sequencer to the store.
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

   // Pixels per page byte and width of a page index.
   localparam int PAGE_ROWS = 8;
   localparam int PAGE_W    = 4;

endpackage

>>> rtl/core/page_framebuffer_vertical_span_unit.sv
// Top level of the page-mode vertical span unit.
// Depends on pfvs_pkg, pfvs_seq and pfvs_store.
`timescale 1ns / 1ps

// Keeps a 1-bit-per-pixel display of PAGES pages by COLUMNS columns, each page
// byte holding 8 vertical pixels with bit 0 on top. A word either sets, inverts
// or clears a vertical run in one column, clipped to the screen, or reads one
// page byte back; every word gives exactly one response word, zero for runs.
// After reset the store is wiped one byte per cycle, and req_ready stays low until
// the whole store is zero. Words are then handled one at a time: a run reads and
// writes back every page byte it touches, a read reads one page byte, and an empty
// or off-screen word touches no byte of the store. The store has a single read port
// and a single write port, which the sequencer overlaps so that one page byte is
// read while the previous one is written back. A finished response waits in an
// output register, and the next word is taken meanwhile.

module page_framebuffer_vertical_span_unit #(
   parameter int COLUMNS = 128,
   parameter int PAGES   = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_opcode,
   input  logic [7:0]        req_column,
   input  logic signed [7:0] req_row_start,
   input  logic [6:0]        req_run_length,
   input  logic [2:0]        req_read_page,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_read_data
);
   import pfvs_pkg::*;

   localparam int DEPTH  = PAGES * COLUMNS;
   localparam int ADDR_W = $clog2(DEPTH);

   mem_ctl_type       mem_ctl;
   logic [ADDR_W-1:0] mem_waddr;
   logic [7:0]        mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;
   logic [7:0]        mem_rdata;

   // Control and clipping.
   pfvs_seq #(
      .COLUMNS (COLUMNS),
      .PAGES   (PAGES),
      .ADDR_W  (ADDR_W)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_column     (req_column),
      .req_row_start  (req_row_start),
      .req_run_length (req_run_length),
      .req_read_page  (req_read_page),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data),
      .mem_ctl        (mem_ctl),
      .mem_waddr      (mem_waddr),
      .mem_wdata      (mem_wdata),
      .mem_raddr      (mem_raddr),
      .mem_rdata      (mem_rdata)
   );

   // Pixel store.
   pfvs_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock (clock),
      .ctl   (mem_ctl),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

endmodule

>>> rtl/core/pfvs_store.sv
// Pixel store: one write port and one registered read port.
// Depends on pfvs_pkg for the port enable struct.
`timescale 1ns / 1ps

module pfvs_store #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  pfvs_pkg::mem_ctl_type ctl,
   input  logic [ADDR_W-1:0]    waddr,
   input  logic [7:0]           wdata,
   input  logic [ADDR_W-1:0]    raddr,
   output logic [7:0]           rdata
);
   import pfvs_pkg::*;

   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[waddr] <= wdata;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/pfvs_seq.sv
// Sequencer: clipping, page masks and the pipelined read-modify-write of the store.
// Depends on pfvs_pkg; drives pfvs_store through the top level.
`timescale 1ns / 1ps

module pfvs_seq #(
   parameter int COLUMNS = 128,
   parameter int PAGES   = 8,
   parameter int ADDR_W  = $clog2(PAGES * COLUMNS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_opcode,
   input  logic [7:0]            req_column,
   input  logic signed [7:0]     req_row_start,
   input  logic [6:0]            req_run_length,
   input  logic [2:0]            req_read_page,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_read_data,
   output pfvs_pkg::mem_ctl_type mem_ctl,
   output logic [ADDR_W-1:0]     mem_waddr,
   output logic [7:0]            mem_wdata,
   output logic [ADDR_W-1:0]     mem_raddr,
   input  logic [7:0]            mem_rdata
);
   import pfvs_pkg::*;

   localparam int ROWS  = PAGES * PAGE_ROWS;
   localparam int DEPTH = PAGES * COLUMNS;

   // Store address of one page byte in one column.
   function automatic logic [ADDR_W-1:0] byte_addr(input logic [PAGE_W-1:0] page,
                                                   input logic [7:0] col);
      return ADDR_W'(int'(page) * COLUMNS + int'(col));
   endfunction

   // Bits of one page that fall inside rows lo .. hi-1.
   function automatic logic [7:0] span_mask(input logic [PAGE_W-1:0] page,
                                            input logic [6:0] lo,
                                            input logic [7:0] hi);
      logic [7:0] base;
      logic [7:0] top;
      logic [2:0] a;
      logic [3:0] b;
      base = {1'b0, page, 3'b000};
      top  = base + 8'd8;
      a    = ({1'b0, lo} > base) ? 3'({1'b0, lo} - base) : 3'd0;
      b    = (hi < top) ? 4'(hi - base) : 4'd8;
      return (8'hff << a) & (8'hff >> (4'd8 - b));
   endfunction

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] wipe_ff, wipe_in;
   op_type            op_ff, op_in;
   logic [7:0]        col_ff, col_in;
   logic [6:0]        lo_ff, lo_in;
   logic [7:0]        hi_ff, hi_in;
   logic [PAGE_W-1:0] rd_page_ff, rd_page_in;
   logic [PAGE_W:0]   left_ff, left_in;
   logic              wr_valid_ff, wr_valid_in;
   logic [PAGE_W-1:0] wr_page_ff, wr_page_in;
   logic [7:0]        res_ff, res_in;
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_data_ff, out_data_in;

   // Clipping of the incoming word.
   op_type            req_op;
   logic signed [9:0] start_ext;
   logic signed [9:0] end_ext;
   logic [6:0]        lo_c;
   logic [7:0]        hi_c;
   logic [7:0]        hi_m1;
   logic              col_on;
   logic              run_empty;
   logic              page_on;
   logic [PAGE_W-1:0] first_page;
   logic [PAGE_W-1:0] last_page;
   logic [7:0]        new_byte;

   always_comb begin
      req_op    = op_type'(req_opcode);
      start_ext = {{2{req_row_start[7]}}, req_row_start};
      end_ext   = start_ext + $signed({3'b000, req_run_length});
      lo_c      = req_row_start[7] ? 7'd0 : req_row_start[6:0];
      col_on    = {1'b0, req_column} < 9'(COLUMNS);
      page_on   = {2'b00, req_read_page} < 5'(PAGES);
      run_empty = !col_on || (end_ext <= $signed({3'b000, lo_c}))
                  || ({1'b0, lo_c} >= 8'(ROWS));
      hi_c      = (end_ext > $signed(10'(ROWS))) ? 8'(ROWS) : end_ext[7:0];
      hi_m1     = hi_c - 8'd1;
      first_page = lo_c[6:3];
      last_page  = hi_m1[6:3];
   end

   // Modified page byte for the word in flight.
   always_comb begin
      new_byte = mem_rdata;
      unique case (op_ff)
         OP_SET:    new_byte = mem_rdata | span_mask(wr_page_ff, lo_ff, hi_ff);
         OP_INVERT: new_byte = mem_rdata ^ span_mask(wr_page_ff, lo_ff, hi_ff);
         OP_CLEAR:  new_byte = mem_rdata & ~span_mask(wr_page_ff, lo_ff, hi_ff);
         OP_READ:   new_byte = mem_rdata;
         default:   new_byte = mem_rdata;
      endcase
   end

   // State register and control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WIPE;
         wipe_ff      <= '0;
         wr_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wipe_ff      <= wipe_in;
         wr_valid_ff  <= wr_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      col_ff      <= col_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      rd_page_ff  <= rd_page_in;
      left_ff     <= left_in;
      wr_page_ff  <= wr_page_in;
      res_ff      <= res_in;
      out_data_ff <= out_data_in;
   end

   // Next state, store accesses and the output register.
   always_comb begin
      state_in     = state_ff;
      wipe_in      = wipe_ff;
      op_in        = op_ff;
      col_in       = col_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rd_page_in   = rd_page_ff;
      left_in      = left_ff;
      wr_valid_in  = 1'b0;
      wr_page_in   = wr_page_ff;
      res_in       = res_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_data_in  = out_data_ff;
      mem_ctl      = '0;
      mem_waddr    = byte_addr(wr_page_ff, col_ff);
      mem_wdata    = new_byte;
      mem_raddr    = byte_addr(rd_page_ff, col_ff);

      unique case (state_ff)
         // Zero the whole store after reset, one byte a cycle.
         ST_WIPE: begin
            mem_ctl.wr_en = 1'b1;
            mem_waddr     = wipe_ff;
            mem_wdata     = 8'h00;
            wipe_in       = wipe_ff + 1'b1;
            if (wipe_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end

         // Take a word and work out which page bytes it touches.
         ST_IDLE: begin
            if (req_valid) begin
               op_in  = req_op;
               col_in = req_column;
               lo_in  = lo_c;
               hi_in  = hi_c;
               res_in = 8'h00;
               if (req_op == OP_READ) begin
                  rd_page_in = {1'b0, req_read_page};
                  left_in    = (PAGE_W + 1)'(1);
                  state_in   = (col_on && page_on) ? ST_RUN : ST_FINISH;
               end else begin
                  rd_page_in = first_page;
                  left_in    = {1'b0, last_page} - {1'b0, first_page} + 1'b1;
                  state_in   = run_empty ? ST_FINISH : ST_RUN;
               end
            end
         end

         // Read one page byte a cycle and write back the one read before.
         ST_RUN: begin
            if (left_ff != '0) begin
               mem_ctl.rd_en = 1'b1;
               rd_page_in    = rd_page_ff + 1'b1;
               left_in       = left_ff - 1'b1;
               wr_valid_in   = 1'b1;
               wr_page_in    = rd_page_ff;
            end
            if (wr_valid_ff) begin
               if (op_ff == OP_READ) begin
                  res_in = mem_rdata;
               end else begin
                  mem_ctl.wr_en = 1'b1;
               end
               if (left_ff == '0) begin
                  state_in = ST_FINISH;
               end
            end
         end

         // Hand the result to the output register once it is free.
         ST_FINISH: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               out_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = out_valid_ff;
   assign rsp_read_data = out_data_ff;

endmodule

>>> rtl/core/pfvs_checker.sv
// Port-level checker of the vertical span unit, bound to the top level.
// Depends on pfvs_pkg and page_framebuffer_vertical_span_unit_assert.svh.
`timescale 1ns / 1ps

`include "page_framebuffer_vertical_span_unit_assert.svh"

module pfvs_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [1:0]        req_opcode,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [7:0]        rsp_read_data
);
   import pfvs_pkg::*;

   logic       push;
   logic       pop;
   logic       is_read;
   logic [1:0] cnt_ff, cnt_in;
   logic       head_read_ff, head_read_in;
   logic       tail_read_ff, tail_read_in;

   assign push    = req_valid && req_ready;
   assign pop     = rsp_valid && rsp_ready;
   assign is_read = (op_type'(req_opcode) == OP_READ);

   // Track which outstanding words are reads, oldest first.
   always_comb begin
      cnt_in       = cnt_ff;
      head_read_in = head_read_ff;
      tail_read_in = tail_read_ff;
      case ({push, pop})
         2'b10: begin
            if (cnt_ff == 2'd0) begin
               head_read_in = is_read;
            end else begin
               tail_read_in = is_read;
            end
            cnt_in = cnt_ff + 2'd1;
         end
         2'b01: begin
            head_read_in = tail_read_ff;
            cnt_in       = cnt_ff - 2'd1;
         end
         2'b11: begin
            if (cnt_ff == 2'd1) begin
               head_read_in = is_read;
            end else begin
               head_read_in = tail_read_ff;
               tail_read_in = is_read;
            end
         end
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      head_read_ff <= head_read_in;
      tail_read_ff <= tail_read_in;
   end

   // The store wipe keeps the unit closed right after reset.
   `PFVS_ASSERT_NEXT(a_closed_after_reset, clock, 1'b0, reset, !req_ready)
   // A stalled response holds its data.
   `PFVS_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(rsp_read_data))
   // A response always belongs to an accepted word.
   `PFVS_ASSERT_NOW(a_rsp_has_word, clock, reset, rsp_valid, cnt_ff != 2'd0)
   // Runs answer with zero.
   `PFVS_ASSERT_NOW(a_run_rsp_zero, clock, reset,
                    rsp_valid && (cnt_ff != 2'd0) && !head_read_ff,
                    rsp_read_data == 8'h00)
   // No more than one word in service plus one waiting response.
   `PFVS_ASSERT_NOW(a_two_outstanding, clock, reset, cnt_ff == 2'd2, !req_ready)

endmodule

bind page_framebuffer_vertical_span_unit pfvs_checker u_pfvs_checker (.*);
